[src/bspl_pkg.sv]
// ----------------------------------------------------------------------------
// bspl_pkg
// Shared types and constants of the bounded sorted priority list.
// ----------------------------------------------------------------------------
package bspl_pkg;

  localparam int MaxEntries = 16;
  localparam int TagBits    = 16;
  localparam int PrioW      = 32;
  localparam int CapW       = 5;
  localparam int CountW     = 5;

  localparam logic [CapW-1:0]         CapReset      = 5'd16;
  localparam logic signed [PrioW-1:0] PrioEmptyLast = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    FuncInsert = 2'd0,
    FuncNext   = 2'd1,
    FuncRewind = 2'd2,
    FuncNop    = 2'd3
  } func_e;

  typedef struct packed {
    func_e                     func;
    logic signed [PrioW-1:0]   priority_req;
    logic [TagBits-1:0]        tag;
  } req_t;

  typedef struct packed {
    logic                      evicted_valid;
    logic [TagBits-1:0]        evicted_tag;
    logic                      next_valid;
    logic [TagBits-1:0]        next_tag;
    logic [CountW-1:0]         count;
    logic [TagBits-1:0]        first_tag;
    logic signed [PrioW-1:0]   first_priority;
    logic signed [PrioW-1:0]   last_priority;
  } rsp_t;

  typedef struct packed {
    logic signed [PrioW-1:0]   prio;
    logic [TagBits-1:0]        tag;
  } entry_t;

endpackage

[src/bspl_store.sv]
// ----------------------------------------------------------------------------
// bspl_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bspl_store #(
  parameter int Depth = bspl_pkg::MaxEntries
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(Depth)-1:0]  wr_addr_i,
  input  bspl_pkg::entry_t          wr_entry_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(Depth)-1:0]  rd_addr_i,
  output bspl_pkg::entry_t          rd_entry_o
);

  bspl_pkg::entry_t mem_q [Depth];
  bspl_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

[src/bounded_sorted_priority_list_core.sv]
// ----------------------------------------------------------------------------
// bounded_sorted_priority_list_core
// Top-K keeper: up to capacity (priority, tag) entries in ascending order.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (req_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (rsp_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (capacity)
//
//  Insert into an empty list writes the entry at once; otherwise it scans the
//  entries at or after the insert point, up to count, from the tail. Read-next
//  reads the cursor entry if any is left; all end with head and tail reads.
//  The single store read port and one priority comparator set the insert cost:
//  the insert walks the list from the tail, one entry per cycle.
//  Reset clears count and cursor and sets capacity to 16; the store needs no clearing.
//  A result waits in the output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
module bounded_sorted_priority_list_core #(
  parameter int MaxEntries = bspl_pkg::MaxEntries
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bspl_pkg::req_t              in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bspl_pkg::rsp_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bspl_pkg::CapW-1:0]   cfg_data_i
);

  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StScan = 7'b0000010,
    StPut  = 7'b0000100,
    StNext = 7'b0001000,
    StHead = 7'b0010000,
    StTail = 7'b0100000,
    StFin  = 7'b1000000
  } state_e;

  function automatic logic [CntW-1:0] eff_cap(input logic [bspl_pkg::CapW-1:0] c);
    logic [CntW-1:0] r;
    if (c == '0) begin
      r = CntW'(1);
    end else if (32'(c) > MaxEntries) begin
      r = CntW'(MaxEntries);
    end else begin
      r = CntW'(c);
    end
    return r;
  endfunction

  state_e                      state_q, state_d;
  logic [CntW-1:0]             fill_q, fill_d;
  logic [CntW-1:0]             cur_q, cur_d;
  logic [bspl_pkg::CapW-1:0]   cap_q, cap_d;
  logic [IdxW-1:0]             j_q, j_d;
  logic                        out_valid_q, out_valid_d;
  bspl_pkg::entry_t            new_q, new_d;
  bspl_pkg::rsp_t              res_q, res_d;
  bspl_pkg::rsp_t              out_q, out_d;

  logic [CntW-1:0]             ecap;
  logic                        wr_en, rd_en;
  logic [IdxW-1:0]             wr_addr, rd_addr;
  bspl_pkg::entry_t            wr_entry, rd_entry;
  logic                        less, drop;

  assign ecap = eff_cap(cap_q);
  assign less = rd_entry.prio < new_q.prio;
  assign drop = (CntW'(j_q) + CntW'(1)) == ecap;

  assign cfg_ready_o = (state_q == StIdle);
  assign in_ready_o  = (state_q == StIdle) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bspl_store #(
    .Depth (MaxEntries)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    cap_d       = cap_q;
    j_d         = j_q;
    new_d       = new_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_entry    = new_q;
    rd_en       = 1'b0;
    rd_addr     = '0;

    unique case (state_q)
      StIdle: begin
        if (cfg_valid_i) begin
          cap_d = cfg_data_i;
          // drop entries beyond the new capacity
          if (fill_q > eff_cap(cfg_data_i)) begin
            fill_d = eff_cap(cfg_data_i);
          end
        end else if (in_valid_i) begin
          new_d.prio = in_data_i.priority_req;
          new_d.tag  = in_data_i.tag;
          res_d      = '0;
          unique case (in_data_i.func)
            bspl_pkg::FuncInsert: begin
              fill_d = (fill_q >= ecap) ? ecap : fill_q + CntW'(1);
              if (fill_q == '0) begin
                wr_en         = 1'b1;
                wr_entry.prio = in_data_i.priority_req;
                wr_entry.tag  = in_data_i.tag;
                state_d       = StHead;
              end else begin
                rd_en   = 1'b1;
                rd_addr = IdxW'(fill_q - CntW'(1));
                j_d     = IdxW'(fill_q - CntW'(1));
                state_d = StScan;
              end
            end
            bspl_pkg::FuncNext: begin
              if (cur_q < fill_q) begin
                rd_en   = 1'b1;
                rd_addr = cur_q[IdxW-1:0];
                state_d = StNext;
              end else begin
                state_d = StHead;
              end
            end
            bspl_pkg::FuncRewind: begin
              cur_d   = '0;
              state_d = StHead;
            end
            bspl_pkg::FuncNop: begin
              state_d = StHead;
            end
          endcase
        end
      end
      StScan: begin
        // rd_entry holds entry j; shift it up or place the new entry above it
        if (less) begin
          if (drop) begin
            res_d.evicted_valid = 1'b1;
            res_d.evicted_tag   = new_q.tag;
          end else begin
            wr_en   = 1'b1;
            wr_addr = j_q + IdxW'(1);
          end
          state_d = StHead;
        end else begin
          if (drop) begin
            res_d.evicted_valid = 1'b1;
            res_d.evicted_tag   = rd_entry.tag;
          end else begin
            wr_en    = 1'b1;
            wr_addr  = j_q + IdxW'(1);
            wr_entry = rd_entry;
          end
          if (j_q == '0) begin
            state_d = StPut;
          end else begin
            j_d     = j_q - IdxW'(1);
            rd_en   = 1'b1;
            rd_addr = j_q - IdxW'(1);
          end
        end
      end
      StPut: begin
        wr_en   = 1'b1;
        state_d = StHead;
      end
      StNext: begin
        res_d.next_valid = 1'b1;
        res_d.next_tag   = rd_entry.tag;
        cur_d            = cur_q + CntW'(1);
        state_d          = StHead;
      end
      StHead: begin
        rd_en   = 1'b1;
        state_d = StTail;
      end
      StTail: begin
        res_d.first_tag      = rd_entry.tag;
        res_d.first_priority = rd_entry.prio;
        rd_en                = 1'b1;
        rd_addr              = IdxW'(fill_q - CntW'(1));
        state_d              = StFin;
      end
      StFin: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_d.count = bspl_pkg::CountW'(fill_q);
          if (fill_q == '0) begin
            out_d.first_tag      = '0;
            out_d.first_priority = '0;
            out_d.last_priority  = bspl_pkg::PrioEmptyLast;
          end else begin
            out_d.last_priority  = rd_entry.prio;
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      cur_q       <= '0;
      cap_q       <= bspl_pkg::CapReset;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cur_q       <= cur_d;
      cap_q       <= cap_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  a_fill_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ecap)
    else $error("fill count exceeds effective capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CntW'(wr_addr) < ecap))
    else $error("store write beyond effective capacity");

  a_scan_below_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CntW'(j_q) < fill_q))
    else $error("scan index outside the held entries");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= CntW'(MaxEntries))
    else $error("read cursor beyond the store");

  a_insert_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.func == bspl_pkg::FuncInsert) &&
     (fill_q != '0)) |=> (state_q == StScan))
    else $error("insert into a non-empty list skipped the scan");

endmodule
